// ----- design/assert_macros.svh -----
// Assertion macros shared by the readout word decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define RTD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define RTD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RTD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RTD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- design/rtdec_pkg.sv -----
// Types and constants of the readout word decoder.
// No dependencies; imported by every module of the block.
package rtdec_pkg;

    // Format codes, sampled from mode on the length word
    localparam logic [1:0] FMT_1881M = 2'd0;
    localparam logic [1:0] FMT_10CX  = 2'd1;
    localparam logic [1:0] FMT_1875A = 2'd2;

    // Record types
    localparam logic REC_HIT    = 1'b0;
    localparam logic REC_STATUS = 1'b1;

    // Measure codes
    localparam logic [1:0] MEAS_CHARGE  = 2'd0;
    localparam logic [1:0] MEAS_TIME    = 2'd1;
    localparam logic [1:0] MEAS_UNCLASS = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_PARITY  = 3'd1;
    localparam logic [2:0] ST_LENGTH  = 3'd2;
    localparam logic [2:0] ST_OVERRUN = 3'd3;
    localparam logic [2:0] ST_GEO     = 3'd4;

    // Result queue sizing
    localparam int PUSH_MAX    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PCNT_W      = $clog2(PUSH_MAX + 1);

    // Sub-event parser phase
    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_HEADER,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  mode;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic        record_type;
        logic [4:0]  geo;
        logic [6:0]  channel;
        logic [14:0] value;
        logic [1:0]  measure;
        logic [2:0]  status;
        logic        final_res;
    } result_t;

    // Results of one decoded word, packed toward index 0
    typedef struct packed {
        logic [PCNT_W-1:0]     count;
        result_t [PUSH_MAX-1:0] rec;
    } push_t;

endpackage

// ----- design/adc_tdc_readout_word_decoder.sv -----
// Top level of the readout word decoder: input register, decode, result queue.
// Depends on rtdec_pkg, rtdec_decode and rtdec_outq.

// One 32-bit readout word is taken per transaction on the item channel and
// turned into zero to three records on the result channel: hits (geo, channel,
// value, measure) and, on the word flagged last, one status record; a non-ok
// status means all hits of that sub-event are to be dropped. A word is held in
// the input register, is decoded in a single pass into a four-entry result
// queue, and its first record is offered in the following cycle. Words are
// accepted every cycle as long as each yields at most one record and the
// result side does not stall; throughput is set by the result port, which
// moves one record per cycle when not stalled. A word is decoded only when at
// most one record is left queued after the current transaction.
module adc_tdc_readout_word_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  rtdec_pkg::in_item_t item,
    output logic                result_valid,
    input  logic                result_stall,
    output rtdec_pkg::result_t  result
);
    import rtdec_pkg::*;

    in_item_t item_reg;
    logic     item_valid_reg;
    logic     room;
    logic     fire;
    push_t    push;

    // Decode the held word when the queue can take its records
    assign fire       = item_valid_reg && room;
    assign item_stall = item_valid_reg && !room;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    rtdec_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .push  (push)
    );

    rtdec_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- design/rtdec_decode.sv -----
// Sub-event state and single-pass decode of one registered readout word.
// Depends on rtdec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtdec_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  rtdec_pkg::in_item_t item,
    output rtdec_pkg::push_t    push
);
    import rtdec_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [31:0] decl_reg, decl_next;
    logic [31:0] ws_reg, ws_next;
    logic [6:0]  left_reg, left_next;
    logic [4:0]  geo_reg, geo_next;
    logic [2:0]  ferr_reg, ferr_next;
    logic        pbad_reg, pbad_next;

    logic        ws_sat;
    logic [31:0] ws_step;
    logic [6:0]  hdr_left;
    logic [7:0]  left_plus;
    logic [32:0] over_sum;
    logic        overrun;
    logic [2:0]  err_code;
    logic        hit_a_v, hit_b_v;
    result_t     hit_a, hit_b, stat_rec;
    logic [31:0] ws_final;
    logic [2:0]  stat_code;
    logic [PCNT_W-1:0] n_res;

    // Word counter step, saturating
    assign ws_sat  = &ws_reg;
    assign ws_step = ws_sat ? ws_reg : ws_reg + 32'd1;

    // Module data word count from a header word
    always_comb
    begin
        hdr_left = '0;
        case (fmt_reg)
            FMT_1881M:
            begin
                hdr_left = (item.word[6:0] > 7'd1) ? item.word[6:0] - 7'd1 : 7'd0;
            end
            FMT_10CX:
            begin
                hdr_left = 7'(({1'b0, item.word[15:10]} + 7'd1) >> 1);
            end
            default:
            begin
                hdr_left = '0;
            end
        endcase
    end

    // Overrun: module words exceed the words still declared
    assign left_plus = ws_sat ? {1'b0, hdr_left} : {1'b0, hdr_left} + 8'd1;
    assign over_sum  = {1'b0, ws_reg} + {25'd0, left_plus};
    assign overrun   = (hdr_left != 7'd0) && (over_sum > {1'b0, decl_reg});

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_LENGTH:
            begin
                phase_next = PH_HEADER;
            end
            PH_HEADER:
            begin
                if ((fmt_reg == FMT_1881M || fmt_reg == FMT_10CX) && hdr_left != 7'd0)
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (left_reg == 7'd1)
                begin
                    phase_next = PH_HEADER;
                end
            end
            default:
            begin
                phase_next = PH_LENGTH;
            end
        endcase
        if (item.last)
        begin
            phase_next = PH_LENGTH;
        end
    end

    // Datapath: state update and hit records
    always_comb
    begin
        fmt_next  = fmt_reg;
        decl_next = decl_reg;
        ws_next   = ws_reg;
        left_next = left_reg;
        geo_next  = geo_reg;
        ferr_next = ferr_reg;
        pbad_next = pbad_reg;
        err_code  = ST_OK;
        hit_a_v   = 1'b0;
        hit_b_v   = 1'b0;
        hit_a     = '0;
        hit_b     = '0;
        unique case (phase_reg) inside
            PH_LENGTH:
            begin
                decl_next = item.word;
                fmt_next  = item.mode;
                ws_next   = '0;
                left_next = '0;
                geo_next  = '0;
                ferr_next = ST_OK;
                pbad_next = 1'b0;
            end
            PH_HEADER, PH_DATA:
            begin
                ws_next = ws_step;
                case (fmt_reg)
                    FMT_1881M:
                    begin
                        if (^item.word)
                        begin
                            pbad_next = 1'b1;
                        end
                        if (phase_reg == PH_HEADER)
                        begin
                            geo_next  = item.word[31:27];
                            left_next = hdr_left;
                            if (overrun)
                            begin
                                err_code = ST_OVERRUN;
                            end
                        end
                        else
                        begin
                            if (item.word[31:27] != geo_reg)
                            begin
                                err_code = ST_GEO;
                            end
                            hit_a_v         = 1'b1;
                            hit_a.geo       = geo_reg;
                            hit_a.channel   = {1'b0, item.word[22:17]};
                            hit_a.value     = {1'b0, item.word[13:0]};
                            hit_a.measure   = MEAS_CHARGE;
                            left_next       = left_reg - 7'd1;
                        end
                    end
                    FMT_10CX:
                    begin
                        if (phase_reg == PH_HEADER)
                        begin
                            geo_next  = item.word[20:16];
                            left_next = hdr_left;
                            if (overrun)
                            begin
                                err_code = ST_OVERRUN;
                            end
                        end
                        else
                        begin
                            // upper half first; a set top bit marks an invalid half
                            hit_a_v       = !item.word[31];
                            hit_a.geo     = geo_reg;
                            hit_a.channel = {2'b0, item.word[30:26]};
                            hit_a.value   = {5'b0, item.word[25:16]};
                            hit_a.measure = MEAS_UNCLASS;
                            hit_b_v       = !item.word[15];
                            hit_b.geo     = geo_reg;
                            hit_b.channel = {2'b0, item.word[14:10]};
                            hit_b.value   = {5'b0, item.word[9:0]};
                            hit_b.measure = MEAS_UNCLASS;
                            left_next     = left_reg - 7'd1;
                        end
                    end
                    FMT_1875A:
                    begin
                        // range bit scales by eight
                        hit_a_v       = 1'b1;
                        hit_a.geo     = item.word[31:27];
                        hit_a.channel = item.word[22:16];
                        hit_a.value   = item.word[23] ? {item.word[11:0], 3'b0}
                                                      : {3'b0, item.word[11:0]};
                        hit_a.measure = MEAS_TIME;
                    end
                    default:
                    begin
                        hit_a_v = 1'b0;
                    end
                endcase
                if (err_code != ST_OK && ferr_reg == ST_OK)
                begin
                    ferr_next = err_code;
                end
            end
            default:
            begin
                hit_a_v = 1'b0;
            end
        endcase
        hit_a.record_type = REC_HIT;
        hit_b.record_type = REC_HIT;
        hit_a.final_res   = !hit_b_v && !item.last;
        hit_b.final_res   = !item.last;
    end

    // End of sub-event status: length, then parity, then first structural error
    assign ws_final = (phase_reg == PH_LENGTH) ? 32'd0 : ws_step;

    always_comb
    begin
        if (ws_final != decl_next)
        begin
            stat_code = ST_LENGTH;
        end
        else if (pbad_next)
        begin
            stat_code = ST_PARITY;
        end
        else
        begin
            stat_code = ferr_next;
        end
        stat_rec             = '0;
        stat_rec.record_type = REC_STATUS;
        stat_rec.status      = stat_code;
        stat_rec.final_res   = 1'b1;
    end

    // Pack valid records toward slot 0
    always_comb
    begin
        push.rec = '0;
        n_res    = '0;
        if (hit_a_v)
        begin
            push.rec[n_res[1:0]] = hit_a;
            n_res                = n_res + PCNT_W'(1);
        end
        if (hit_b_v)
        begin
            push.rec[n_res[1:0]] = hit_b;
            n_res                = n_res + PCNT_W'(1);
        end
        if (item.last)
        begin
            push.rec[n_res[1:0]] = stat_rec;
            n_res                = n_res + PCNT_W'(1);
        end
        push.count = fire ? n_res : '0;
    end

    // Sub-event state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LENGTH;
            fmt_reg   <= '0;
            decl_reg  <= '0;
            ws_reg    <= '0;
            left_reg  <= '0;
            geo_reg   <= '0;
            ferr_reg  <= ST_OK;
            pbad_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            fmt_reg   <= fmt_next;
            decl_reg  <= decl_next;
            ws_reg    <= ws_next;
            left_reg  <= left_next;
            geo_reg   <= geo_next;
            ferr_reg  <= ferr_next;
            pbad_reg  <= pbad_next;
        end
    end

    `RTD_ASSERT_IMP(a_data_has_words, clk, rst_n, phase_reg == PH_DATA, left_reg != 7'd0, "module data phase with no words left")
    `RTD_ASSERT_IMP(a_three_need_last, clk, rst_n, push.count == PCNT_W'(PUSH_MAX), item.last, "three results without a status record")

endmodule

// ----- design/rtdec_outq.sv -----
// Result queue: takes up to three records per cycle, hands out one per cycle unless stalled.
// Depends on rtdec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtdec_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  rtdec_pkg::push_t   push,
    output logic               room,
    output logic               result_valid,
    input  logic               result_stall,
    output rtdec_pkg::result_t result
);
    import rtdec_pkg::*;

    result_t q_reg [QUEUE_DEPTH];
    result_t q_next [QUEUE_DEPTH];
    result_t q_up [QUEUE_DEPTH];
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [QCNT_W-1:0] base;
    logic              pop;

    // Head of queue drives the port
    assign result_valid = (cnt_reg != '0);
    assign result       = q_reg[0];
    assign pop          = result_valid && !result_stall;
    assign base         = cnt_reg - QCNT_W'(pop);
    assign room         = (base <= QCNT_W'(QUEUE_DEPTH - PUSH_MAX));

    // Entry contents after a pop shift
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_up
        if (i < QUEUE_DEPTH - 1)
        begin : g_mid
            assign q_up[i] = pop ? q_reg[i + 1] : q_reg[i];
        end
        else
        begin : g_top
            assign q_up[i] = q_reg[i];
        end
    end

    // Kept entries shift down, new records append behind them
    always_comb
    begin
        logic [QCNT_W-1:0] off;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            off = QCNT_W'(i) - base;
            if (QCNT_W'(i) < base)
            begin
                q_next[i] = q_up[i];
            end
            else if (off < QCNT_W'(push.count))
            begin
                q_next[i] = push.rec[off[PCNT_W-1:0]];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
        end
        cnt_next = base + QCNT_W'(push.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    `RTD_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= QCNT_W'(QUEUE_DEPTH), "result queue count beyond depth")
    `RTD_ASSERT_IMP(a_push_room, clk, rst_n, push.count != '0, room, "records pushed without room")
    `RTD_ASSERT_IMP(a_status_final, clk, rst_n, result_valid && result.record_type == REC_STATUS, result.final_res, "status record not marked final")

endmodule

// ----- tb/adc_tdc_readout_word_decoder_tb.sv -----
// Testbench of the readout word decoder: directed rows, then random sub-events.
// Every record is checked against an in-bench model of the sub-event decoder.
// Depends on rtdec_pkg and the adc_tdc_readout_word_decoder RTL.
module adc_tdc_readout_word_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtdec_pkg::*;

    // Format code with no decoder behind it
    localparam logic [1:0] FMT_UNKNOWN = 2'd3;

    localparam int RANDOM_WORDS     = 250;
    localparam int CYCLE_LIMIT      = 60000;
    localparam int HOLD_OFF_AT      = 60;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int PAUSE_ROW        = 150;
    localparam int STEADY_ROW_FIRST = 180;
    localparam int STEADY_ROW_LAST  = 230;
    localparam int STEADY_REC_FIRST = 150;
    localparam int STEADY_REC_LAST  = 250;
    localparam int REPORT_MAX       = 10;
    localparam int DRAIN_CYCLES     = 16;

    // One stimulus row; typed rows carry a hand-written closing status
    typedef struct packed {
        in_item_t   item;
        logic       typed;
        logic [2:0] want_status;
    } stim_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     item_valid;
    logic     item_stall;
    in_item_t item;
    logic     result_valid;
    logic     result_stall;
    result_t  result;

    stim_row_t stim_rows[$];
    result_t   expected_records[$];
    int        words_accepted  = 0;
    int        records_checked = 0;
    int        mismatch_count  = 0;

    // Sub-event decoder model state
    phase_t      dec_phase      = PH_LENGTH;
    logic [1:0]  dec_format     = FMT_1881M;
    logic [31:0] dec_length     = '0;
    logic [31:0] dec_seen       = '0;
    logic [6:0]  dec_left       = '0;
    logic [4:0]  dec_geo        = '0;
    logic [2:0]  dec_error      = ST_OK;
    logic        dec_parity_bad = 1'b0;

    adc_tdc_readout_word_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Reset once
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Flip the spare bit 16 so the word has even parity
    function automatic logic [31:0] even_word(input logic [31:0] w);
        return w ^ {15'd0, ^w, 16'd0};
    endfunction

    function automatic result_t hit_record(input logic [4:0] geo, input logic [6:0] channel,
                                           input logic [14:0] value, input logic [1:0] measure);
        result_t r;
        r             = '0;
        r.record_type = REC_HIT;
        r.geo         = geo;
        r.channel     = channel;
        r.value       = value;
        r.measure     = measure;
        r.status      = ST_OK;
        return r;
    endfunction

    function automatic string describe(input result_t r);
        return $sformatf("type=%0d geo=%0d ch=%0d val=%0d meas=%0d st=%0d final=%0d",
                         r.record_type, r.geo, r.channel, r.value, r.measure, r.status,
                         r.final_res);
    endfunction

    // Keep only the first structural error of the sub-event
    task automatic note_error(input logic [2:0] code);
        if (dec_error == ST_OK)
            dec_error = code;
    endtask

    // Decode one accepted word and queue the records it yields
    task automatic decode_word(input in_item_t w);
        result_t     recs[$];
        result_t     rec;
        logic [31:0] remaining;
        logic [15:0] half;
        if (dec_phase == PH_LENGTH)
        begin
            dec_length     = w.word;
            dec_format     = w.mode;
            dec_seen       = '0;
            dec_left       = '0;
            dec_geo        = '0;
            dec_error      = ST_OK;
            dec_parity_bad = 1'b0;
            dec_phase      = PH_HEADER;
        end
        else
        begin
            if (dec_seen != '1)
                dec_seen++;
            remaining = (dec_length >= dec_seen) ? dec_length - dec_seen : '0;
            case (dec_format)
                FMT_1881M:
                begin
                    if (^w.word)
                        dec_parity_bad = 1'b1;
                    if (dec_phase != PH_DATA)
                    begin
                        // module header: count includes the header itself
                        dec_geo  = w.word[31:27];
                        dec_left = (w.word[6:0] > 7'd1) ? w.word[6:0] - 7'd1 : 7'd0;
                        if ({25'd0, dec_left} > remaining)
                            note_error(ST_OVERRUN);
                        dec_phase = (dec_left != 0) ? PH_DATA : PH_HEADER;
                    end
                    else
                    begin
                        if (w.word[31:27] != dec_geo)
                            note_error(ST_GEO);
                        recs.push_back(hit_record(dec_geo, {1'b0, w.word[22:17]},
                                                  {1'b0, w.word[13:0]}, MEAS_CHARGE));
                        dec_left--;
                        if (dec_left == 0)
                            dec_phase = PH_HEADER;
                    end
                end
                FMT_10CX:
                begin
                    if (dec_phase != PH_DATA)
                    begin
                        // two channels per data word
                        dec_geo  = w.word[20:16];
                        dec_left = ({1'b0, w.word[15:10]} + 7'd1) >> 1;
                        if ({25'd0, dec_left} > remaining)
                            note_error(ST_OVERRUN);
                        dec_phase = (dec_left != 0) ? PH_DATA : PH_HEADER;
                    end
                    else
                    begin
                        // upper half first; bit 15 marks an invalid half
                        for (int h = 1; h >= 0; h--)
                        begin
                            half = w.word[16*h +: 16];
                            if (!half[15])
                                recs.push_back(hit_record(dec_geo, {2'b0, half[14:10]},
                                                          {5'b0, half[9:0]}, MEAS_UNCLASS));
                        end
                        dec_left--;
                        if (dec_left == 0)
                            dec_phase = PH_HEADER;
                    end
                end
                FMT_1875A:
                begin
                    // range bit scales the value by eight
                    recs.push_back(hit_record(w.word[31:27], w.word[22:16],
                                              w.word[23] ? {w.word[11:0], 3'b0}
                                                         : {3'b0, w.word[11:0]},
                                              MEAS_TIME));
                end
                default:
                begin
                end
            endcase
        end

        // Closing status: length beats parity beats structure
        if (w.last)
        begin
            rec             = '0;
            rec.record_type = REC_STATUS;
            if (dec_seen != dec_length)
                rec.status = ST_LENGTH;
            else if (dec_parity_bad)
                rec.status = ST_PARITY;
            else
                rec.status = dec_error;
            recs.push_back(rec);
            dec_phase = PH_LENGTH;
        end

        foreach (recs[i])
        begin
            rec           = recs[i];
            rec.final_res = (i == recs.size() - 1);
            expected_records.push_back(rec);
        end
    endtask

    task automatic add_row(input logic [31:0] w, input logic [1:0] m, input logic l,
                           input logic typed = 1'b0, input logic [2:0] want = ST_OK);
        stim_row_t r;
        r.item.word   = w;
        r.item.mode   = m;
        r.item.last   = l;
        r.typed       = typed;
        r.want_status = want;
        stim_rows.push_back(r);
    endtask

    // One random sub-event, mostly well formed; sometimes just noise words
    task automatic add_random_subevent();
        logic [31:0] body[$];
        logic [31:0] w;
        logic [31:0] len;
        logic [1:0]  fmt;
        logic [4:0]  g;
        int          roll;
        int          nmod;
        int          cnt;
        int          ndat;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            repeat ($urandom_range(1, 3))
                add_row($urandom, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            return;
        end
        roll = $urandom_range(0, 99);
        fmt  = (roll < 30) ? FMT_1881M : (roll < 60) ? FMT_10CX :
               (roll < 90) ? FMT_1875A : FMT_UNKNOWN;
        case (fmt)
            FMT_1881M:
            begin
                for (nmod = $urandom_range(0, 3); nmod > 0; nmod--)
                begin
                    g = 5'($urandom);
                    cnt = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 127)
                                                       : $urandom_range(0, 5);
                    w        = $urandom;
                    w[31:27] = g;
                    w[6:0]   = 7'(cnt);
                    if ($urandom_range(0, 99) < 95)
                        w = even_word(w);
                    body.push_back(w);
                    // long modules are cut short to keep sub-events small
                    ndat = (cnt > 1) ? cnt - 1 : 0;
                    if (ndat > 6)
                        ndat = $urandom_range(0, 6);
                    repeat (ndat)
                    begin
                        w = $urandom;
                        if ($urandom_range(0, 99) < 90)
                            w[31:27] = g;
                        if ($urandom_range(0, 99) < 95)
                            w = even_word(w);
                        body.push_back(w);
                    end
                end
            end
            FMT_10CX:
            begin
                for (nmod = $urandom_range(0, 3); nmod > 0; nmod--)
                begin
                    cnt = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, 8);
                    w        = $urandom;
                    w[15:10] = 6'(cnt);
                    body.push_back(w);
                    ndat = (cnt + 1) / 2;
                    if (ndat > 6)
                        ndat = $urandom_range(0, 6);
                    repeat (ndat)
                        body.push_back($urandom);
                end
            end
            FMT_1875A:
            begin
                repeat ($urandom_range(0, 8))
                    body.push_back($urandom);
            end
            default:
            begin
                repeat ($urandom_range(0, 3))
                    body.push_back($urandom);
            end
        endcase

        // Declared length: mostly right, sometimes off by one or arbitrary
        roll = $urandom_range(0, 99);
        len  = body.size();
        if (roll >= 94)
            len = $urandom;
        else if (roll >= 88)
            len = len + 1;
        else if (roll >= 82 && len != 0)
            len = len - 1;
        add_row(len, fmt, body.size() == 0);
        foreach (body[i])
            add_row(body[i], 2'($urandom_range(0, 3)), i == body.size() - 1);
    endtask

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t ns: %s\n  expected %s\n  actual   %s", $time, what,
                     describe(want), describe(got));
    endtask

    // Word source: directed rows, random sub-events, then drain and verdict
    initial
    begin : word_source
        int        first_random;
        int        row;
        stim_row_t cur;
        result_t   rec;
        item_valid <= 1'b0;
        item       <= '0;

        // length word alone: empty sub-event, then declared lengths never met
        add_row(32'd0, FMT_1881M, 1'b1, 1'b1, ST_OK);
        add_row(32'd5, FMT_10CX, 1'b1, 1'b1, ST_LENGTH);
        add_row(32'hffff_ffff, FMT_1875A, 1'b1, 1'b1, ST_LENGTH);
        // 1881M: data words at the field extremes
        add_row(32'd3, FMT_1881M, 1'b0);
        add_row(even_word({5'd31, 20'd0, 7'd3}), FMT_1881M, 1'b0);
        add_row(even_word({5'd31, 4'd0, 6'd63, 3'd0, 14'h3fff}), FMT_1881M, 1'b0);
        add_row(even_word({5'd31, 4'd0, 6'd0, 3'd0, 14'd0}), FMT_1881M, 1'b1, 1'b1, ST_OK);
        // 1881M: empty module header with odd parity
        add_row(32'd1, FMT_1881M, 1'b0);
        add_row(even_word({5'd2, 20'd0, 7'd1}) ^ 32'h100, FMT_1881M, 1'b1, 1'b1, ST_PARITY);
        // 1881M: data word from another geo
        add_row(32'd2, FMT_1881M, 1'b0);
        add_row(even_word({5'd3, 20'd0, 7'd2}), FMT_1881M, 1'b0);
        add_row(even_word({5'd4, 4'd0, 6'd5, 3'd0, 14'd100}), FMT_1881M, 1'b1, 1'b1, ST_GEO);
        // 1881M: module count far past the declared length
        add_row(32'd2, FMT_1881M, 1'b0);
        add_row(even_word({5'd7, 20'd0, 7'd127}), FMT_1881M, 1'b0);
        add_row(even_word({5'd7, 4'd0, 6'd1, 3'd0, 14'd1}), FMT_1881M, 1'b1, 1'b1,
                ST_OVERRUN);
        // 10CX: both halves hit, then a skipped upper half with the status
        add_row(32'd3, FMT_10CX, 1'b0);
        add_row({11'd0, 5'd17, 6'd3, 10'd0}, FMT_10CX, 1'b0);
        add_row({1'b0, 5'd31, 10'h3ff, 1'b0, 5'd0, 10'd0}, FMT_10CX, 1'b0);
        add_row({1'b1, 15'h7fff, 1'b0, 5'd9, 10'd512}, FMT_10CX, 1'b1, 1'b1, ST_OK);
        // 1875A: range bit at full scale, then an all-zero word
        add_row(32'd2, FMT_1875A, 1'b0);
        add_row({5'd31, 3'd0, 1'b1, 7'd127, 4'd0, 12'hfff}, FMT_1875A, 1'b0);
        add_row(32'd0, FMT_1875A, 1'b1, 1'b1, ST_OK);
        // unknown format: words decode to nothing
        add_row(32'd1, FMT_UNKNOWN, 1'b0);
        add_row(32'hffff_ffff, FMT_UNKNOWN, 1'b1, 1'b1, ST_OK);

        first_random = stim_rows.size();
        while (stim_rows.size() - first_random < RANDOM_WORDS)
            add_random_subevent();

        wait (rst_n);
        @(posedge clk);
        for (row = 0; row < stim_rows.size(); row++)
        begin
            cur = stim_rows[row];
            // hold back once until every queued record is out
            if (row == PAUSE_ROW)
            begin
                item_valid <= 1'b0;
                do @(posedge clk); while (expected_records.size() != 0);
            end
            if (row < STEADY_ROW_FIRST || row >= STEADY_ROW_LAST)
            begin
                while ($urandom_range(0, 99) < 15)
                begin
                    item_valid <= 1'b0;
                    @(posedge clk);
                end
            end
            item_valid <= 1'b1;
            item       <= cur.item;
            do @(posedge clk); while (item_stall);
            words_accepted++;
            decode_word(cur.item);
            // typed rows end in the status record; check it against the table
            if (cur.typed)
            begin
                rec        = expected_records.pop_back();
                rec.status = cur.want_status;
                expected_records.push_back(rec);
            end
        end
        item_valid <= 1'b0;

        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stall, one long hold-off, one stall-free stretch
    initial
    begin : record_sink
        int  hold;
        bit  held_off;
        held_off = 1'b0;
        result_stall <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && words_accepted >= HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                result_stall <= 1'b1;
                for (hold = 0; hold < HOLD_OFF_CYCLES; hold++)
                    @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (records_checked >= STEADY_REC_FIRST && records_checked < STEADY_REC_LAST)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(0, 99) < 15);
        end
    end

    // Compare each record transaction with the oldest expectation
    always @(posedge clk)
    begin : record_check
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            records_checked++;
            if (expected_records.size() == 0)
                report_mismatch("record with nothing expected", '0, result);
            else
            begin
                want = expected_records[0];
                expected_records.delete(0);
                if (result.record_type !== want.record_type || result.geo !== want.geo ||
                    result.channel !== want.channel || result.value !== want.value ||
                    result.measure !== want.measure || result.status !== want.status ||
                    result.final_res !== want.final_res)
                    report_mismatch("record mismatch", want, result);
            end
        end
    end

    // Run limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
